// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deque RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed: %m");
// Check that a condition in one cycle leads to a result in the next.
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define DQ_ASSERT(lbl, clk, rstn, prop)
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/dq_pkg.sv =====
// Types, constants and codes of the double-ended queue.
package dq_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned WordW        = 32;
  localparam int unsigned OccW         = 7;

  localparam logic signed [WordW-1:0] EmptyWord = -32'sd1;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_POP_FRONT  = 2'd1,
    REQ_PUSH_BACK  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  // Operation broadcast to every cell of one chain.
  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_SHIFT_IN  = 3'd1,
    OP_SHIFT_OUT = 3'd2,
    OP_APPEND    = 3'd3,
    OP_TRIM      = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic signed [WordW-1:0] word;
  } chain_cmd_t;

endpackage

// ===== rtl/dq_if.sv =====
// Request and response channel interfaces of the deque.
interface dq_req_if
  import dq_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [WordW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dq_rsp_if
  import dq_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] pop_data;
  logic                    was_empty;
  logic                    dropped_full;
  logic                    all_match;
  logic [OccW-1:0]         occupancy;

  modport source (output valid, output pop_data, output was_empty, output dropped_full,
                  output all_match, output occupancy, input ready);
  modport sink   (input valid, input pop_data, input was_empty, input dropped_full,
                  input all_match, input occupancy, output ready);
endinterface

// ===== rtl/dq_cell.sv =====
// One storage cell of a deque chain: a word and its valid bit.
module dq_cell
  import dq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  chain_cmd_t              cmd_i,
  input  logic signed [WordW-1:0] left_data_i,
  input  logic                    left_valid_i,
  input  logic signed [WordW-1:0] right_data_i,
  input  logic                    right_valid_i,
  output logic signed [WordW-1:0] data_o,
  output logic                    valid_o
);

  logic signed [WordW-1:0] data_q, data_d;
  logic                    valid_q, valid_d;

  // Pick the next content from the neighbors or the broadcast word
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (cmd_i.op)
      OP_SHIFT_IN: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      OP_SHIFT_OUT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      OP_APPEND: begin
        // take the word only at the boundary of the occupied run
        if (!valid_q && left_valid_i) begin
          data_d  = cmd_i.word;
          valid_d = 1'b1;
        end
      end
      OP_TRIM: begin
        // drop the last occupied cell
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/dq_chain.sv =====
// Row of deque cells with the head at cell zero.
`include "assert_macros.svh"

module dq_chain
  import dq_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  chain_cmd_t              cmd_i,
  output logic signed [WordW-1:0] head_o
);

  logic signed [WordW-1:0] data_w [Depth];
  logic [Depth-1:0]        valid_w;

  // Link each cell to its neighbors; the head sees the new word
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [WordW-1:0] left_data, right_data;
    logic                    left_valid, right_valid;

    if (i == 0) begin : g_head
      assign left_data  = cmd_i.word;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = data_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_data  = data_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (data_w[i]),
      .valid_o      (valid_w[i])
    );
  end

  assign head_o = data_w[0];

  // Occupied cells form one run from the head: valid plus one is a power of two
  logic [Depth:0] run_chk;
  assign run_chk = {1'b0, valid_w} + {{Depth{1'b0}}, 1'b1};

  `DQ_ASSERT(valid_run_a, clk_i, rst_ni, $onehot(run_chk))
  `DQ_ASSERT_NEXT(shift_in_head_a, clk_i, rst_ni, cmd_i.op == OP_SHIFT_IN, valid_w[0])
  `DQ_ASSERT_NEXT(trim_one_a, clk_i, rst_ni, cmd_i.op == OP_TRIM && valid_w != '0,
                  $countones(valid_w) == $countones($past(valid_w)) - 1)

endmodule

// ===== rtl/dq_ctrl.sv =====
// Request decode, count, match flag and response register of the deque.
`include "assert_macros.svh"

module dq_ctrl
  import dq_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  dq_req_if.sink                  req_i,
  dq_rsp_if.source                rsp_o,
  input  logic signed [WordW-1:0] head_a_i,
  input  logic signed [WordW-1:0] head_b_i,
  output chain_cmd_t              cmd_a_o,
  output chain_cmd_t              cmd_b_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0]         count_q, count_d;
  logic                    match_q, match_d;
  logic                    rsp_valid_q;
  logic signed [WordW-1:0] data_q, data_d;
  logic                    empty_q, empty_d;
  logic                    drop_q, drop_d;
  logic [OccW-1:0]         occ_q;

  logic req_acc, is_push, is_pop, full, empty;
  req_e req;

  assign req     = req_e'(req_i.req_type);
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_acc = req_i.valid && req_i.ready;
  assign is_push = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK);
  assign is_pop  = !is_push;
  assign full    = count_q == CntW'(Depth);
  assign empty   = count_q == '0;

  // Decode the word into chain operations and the result fields
  always_comb begin
    cmd_a_o = '{op: OP_HOLD, word: req_i.value};
    cmd_b_o = '{op: OP_HOLD, word: req_i.value};
    count_d = count_q;
    match_d = match_q;
    data_d  = '0;
    empty_d = 1'b0;
    drop_d  = 1'b0;
    if (req_acc) begin
      case (req)
        REQ_PUSH_FRONT: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            cmd_a_o.op = OP_SHIFT_IN;
            cmd_b_o.op = OP_APPEND;
            count_d    = count_q + CntW'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            cmd_b_o.op = OP_SHIFT_IN;
            cmd_a_o.op = OP_APPEND;
            count_d    = count_q + CntW'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            empty_d = 1'b1;
            data_d  = EmptyWord;
          end else begin
            cmd_a_o.op = OP_SHIFT_OUT;
            cmd_b_o.op = OP_TRIM;
            data_d     = head_a_i;
            count_d    = count_q - CntW'(1);
          end
          match_d = match_q && (data_d == req_i.value);
        end
        REQ_POP_BACK: begin
          if (empty) begin
            empty_d = 1'b1;
            data_d  = EmptyWord;
          end else begin
            cmd_b_o.op = OP_SHIFT_OUT;
            cmd_a_o.op = OP_TRIM;
            data_d     = head_b_i;
            count_d    = count_q - CntW'(1);
          end
          match_d = match_q && (data_d == req_i.value);
        end
        default: ;
      endcase
    end
  end

  // Hold control state; the response stays until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      match_q     <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      match_q <= match_d;
      if (req_acc) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Load the response payload with each accepted word
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      data_q  <= data_d;
      empty_q <= empty_d;
      drop_q  <= drop_d;
      occ_q   <= OccW'(count_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.pop_data     = data_q;
  assign rsp_o.was_empty    = empty_q;
  assign rsp_o.dropped_full = drop_q;
  assign rsp_o.all_match    = match_q;
  assign rsp_o.occupancy    = occ_q;

  `DQ_ASSERT(count_bound_a, clk_i, rst_ni, count_q <= CntW'(Depth))
  `DQ_ASSERT(match_fall_a, clk_i, rst_ni, $fell(match_q) |-> $past(req_acc && is_pop))
  `DQ_ASSERT_NEXT(full_hold_a, clk_i, rst_ni, req_acc && is_push && full,
                  count_q == $past(count_q) && drop_q)
  `DQ_ASSERT_NEXT(empty_hold_a, clk_i, rst_ni, req_acc && is_pop && empty,
                  count_q == '0 && empty_q && data_q == EmptyWord)

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Top level of the double-ended queue built from two mirrored cell chains.
//
//   channel  direction  word fields
//   req_i    in         req_type, value
//   rsp_o    out        pop_data, was_empty, dropped_full, all_match, occupancy
//
// One request per cycle unless the response stalls; the response is valid in the
// cycle after acceptance, from the response register. Chain A holds the words
// front first and chain B back first, so both pops read a head cell and every
// update is a neighbor step. Reset clears all cell valid bits at once, so no
// clearing pass is needed. A stalled response holds its register; a new request
// is taken in the same cycle that the waiting response is taken.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int unsigned Depth = DepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);

  chain_cmd_t              cmd_a, cmd_b;
  logic signed [WordW-1:0] head_a, head_b;

  // Decode requests and register responses
  dq_ctrl #(.Depth(Depth)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .head_a_i(head_a),
    .head_b_i(head_b),
    .cmd_a_o (cmd_a),
    .cmd_b_o (cmd_b)
  );

  // Front-first copy of the queue
  dq_chain #(.Depth(Depth)) u_chain_a (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_a),
    .head_o(head_a)
  );

  // Back-first copy of the queue
  dq_chain #(.Depth(Depth)) u_chain_b (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_b),
    .head_o(head_b)
  );

endmodule
